/* rtl/chunked_oneshot_us_timer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the one-shot microsecond timer
// Checks are compiled in simulation only; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_ONESHOT_US_TIMER_UNIT_DEFINES_SVH
`define CHUNKED_ONESHOT_US_TIMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is held
`define COSUT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also runs through reset
`define COSUT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define COSUT_ASSERT(lbl, prop, msg)
`define COSUT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/cosut_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosut_pkg
// Shared types and constants of the chunked one-shot microsecond timer.
// ----------------------------------------------------------------------------
package cosut_pkg;

    localparam int DELAY_W  = 32;
    localparam int QUOT_W   = 23;   // ceil((2^32 - 1) / 1000) fits
    localparam int PRE_W    = 8;
    localparam int OVF_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_US_PRESCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_PRESCALE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MS_SWITCH_US = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK_MS = 3'd4;

    // register reset values
    localparam logic [7:0]  US_PRESCALE_RST  = 8'd39;
    localparam logic [7:0]  MS_PRESCALE_RST  = 8'd199;
    localparam logic [15:0] MS_SWITCH_US_RST = 16'd10000;
    localparam logic [7:0]  TICKS_PER_MS_RST = 8'd200;
    localparam logic [9:0]  MAX_CHUNK_MS_RST = 10'd327;

    localparam int CHUNK_TICKS_RST = 2000;

    // y / 125 for y < 2^30: floor(y * DIV_RECIP >> 31) is exact or one high
    localparam logic [24:0] DIV_RECIP = 25'd17179870;
    // y / 125 for y < 2^14: floor(y * US_RECIP >> 21) is exact
    localparam logic [14:0] US_RECIP  = 15'd16778;
    localparam logic [19:0] US_PER_MS = 20'd1000;
    localparam logic [16:0] CEIL_ADD  = 17'd999;

    typedef struct packed {
        logic [7:0]  us_prescale;
        logic [7:0]  ms_prescale;
        logic [15:0] ms_switch_us;
        logic [7:0]  ticks_per_ms;
        logic [9:0]  max_chunk_ms;
    } t_cfg;

    // item on its way to the timer core, delay already forced to at least 1
    typedef struct packed {
        logic               req_type;
        logic [DELAY_W-1:0] delay_us;
        logic [QUOT_W-1:0]  quot;       // ceil(delay_us / 1000)
    } t_item;

endpackage

/* rtl/chunked_oneshot_us_timer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_oneshot_us_timer_unit
// One-shot delay timer: prescaler plus chunked down counter, stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction: tuser = 0 is one system clock
//   tick, tuser = 1 starts a delay of tdata microseconds (0 counts as 1); a
//   start drops any delay in progress.
//   m_axis returns one result per item: expired pulse, busy flag and the
//   running count of counter overflows.
//   The config channel writes registers 0..4 (us_prescale, ms_prescale,
//   ms_switch_us, ticks_per_ms, max_chunk_ms); it is always ready and an
//   unknown index is ignored.
// Timing:
//   m_axis_tvalid rises once the item has passed the input register, the
//   two-stage ceil(delay / 1000) pipeline and the result register loaded by
//   the timer state update. One item is taken every cycle unless m_axis stalls.
// Reset and stall:
//   Synchronous reset loads the default registers, stops the timer and
//   empties the pipeline. When m_axis stalls, empty stages still fill, then
//   s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module chunked_oneshot_us_timer_unit
    import cosut_pkg::*;
#(
    parameter int COUNTER_RANGE = 65536
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [31:0] delay_us
    input  logic                  s_axis_tuser,   // [0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [0] expired, [1] busy_res,
                                                  // [33:2] overflow_count, [39:34] zero
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    t_item            w_item;
    logic             w_item_valid;
    logic             w_item_ready;
    logic             w_expired;
    logic             w_busy;
    logic [OVF_W-1:0] w_overflows;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.us_prescale  <= US_PRESCALE_RST;
            r_cfg.ms_prescale  <= MS_PRESCALE_RST;
            r_cfg.ms_switch_us <= MS_SWITCH_US_RST;
            r_cfg.ticks_per_ms <= TICKS_PER_MS_RST;
            r_cfg.max_chunk_ms <= MAX_CHUNK_MS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_US_PRESCALE:  r_cfg.us_prescale  <= i_cfg_data[7:0];
                CFG_MS_PRESCALE:  r_cfg.ms_prescale  <= i_cfg_data[7:0];
                CFG_MS_SWITCH_US: r_cfg.ms_switch_us <= i_cfg_data;
                CFG_TICKS_PER_MS: r_cfg.ticks_per_ms <= i_cfg_data[7:0];
                CFG_MAX_CHUNK_MS: r_cfg.max_chunk_ms <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    cosut_div1000 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_delay_us (s_axis_tdata),
        .o_valid    (w_item_valid),
        .i_ready    (w_item_ready),
        .o_item     (w_item)
    );

    cosut_core #(
        .COUNTER_RANGE (COUNTER_RANGE)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (w_item_valid),
        .o_ready     (w_item_ready),
        .i_item      (w_item),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_expired   (w_expired),
        .o_busy      (w_busy),
        .o_overflows (w_overflows)
    );

    assign m_axis_tdata = {6'b0, w_overflows, w_busy, w_expired};

endmodule

/* rtl/cosut_div1000.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosut_div1000
// Input register and two-stage ceil(delay / 1000) pipeline with stall.
// ----------------------------------------------------------------------------
module cosut_div1000
    import cosut_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [DELAY_W-1:0] i_delay_us,
    output logic               o_valid,
    input  logic               i_ready,
    output t_item              o_item
);

    logic               r_v1, r_v2, r_v3;
    logic               r_req1, r_req2;
    logic [DELAY_W-1:0] r_d1, r_d2;
    logic [29:0]        r_y2;
    logic [23:0]        r_q2;
    t_item              r_item3;

    logic               w_en1, w_en2, w_en3;
    logic [DELAY_W-1:0] n_d1;
    logic [32:0]        w_x;
    logic [29:0]        n_y2;
    logic [54:0]        w_prod;
    logic [30:0]        w_q125;
    logic [23:0]        n_q3;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // a zero delay counts as 1 us
    assign n_d1 = (i_delay_us == '0) ? DELAY_W'(1) : i_delay_us;

    // ceil(d / 1000) = floor(floor((d + 999) / 8) / 125)
    assign w_x    = {1'b0, r_d1} + 33'(CEIL_ADD);
    assign n_y2   = w_x[32:3];
    assign w_prod = {25'b0, n_y2} * {30'b0, DIV_RECIP};

    // estimate may be one high: fix with one compare
    assign w_q125 = {r_q2, 7'b0} - {6'b0, r_q2, 1'b0} - {7'b0, r_q2};
    assign n_q3   = (w_q125 > {1'b0, r_y2}) ? r_q2 - 24'd1 : r_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_req1 <= i_req_type;
            r_d1   <= n_d1;
        end
        if (w_en2) begin
            r_req2 <= r_req1;
            r_d2   <= r_d1;
            r_y2   <= n_y2;
            r_q2   <= w_prod[54:31];
        end
        if (w_en3) begin
            r_item3.req_type <= r_req2;
            r_item3.delay_us <= r_d2;
            r_item3.quot     <= n_q3[QUOT_W-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;

endmodule

/* rtl/cosut_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosut_core
// Prescaler, chunk counter, chunk planner and the result register.
// ----------------------------------------------------------------------------
`include "chunked_oneshot_us_timer_unit_defines.svh"

module cosut_core
    import cosut_pkg::*;
#(
    parameter int COUNTER_RANGE = 65536
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_item            i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_expired,
    output logic             o_busy,
    output logic [OVF_W-1:0] o_overflows
);

    localparam int CW = $clog2(COUNTER_RANGE);
    localparam logic [CW-1:0] LIM = CW'(COUNTER_RANGE - 1);

    // timer state
    logic [PRE_W-1:0]   r_pc;
    logic [CW-1:0]      r_ctl;
    logic               r_ms;
    logic [DELAY_W-1:0] r_rem;
    logic [QUOT_W-1:0]  r_q;       // always ceil(r_rem / 1000)
    logic               r_run;
    logic [OVF_W-1:0]   r_ovf;

    // result register
    logic               r_ovalid;
    logic               r_oexp;
    logic               r_obusy;
    logic [OVF_W-1:0]   r_oovf;

    logic               w_acc;
    logic               w_start;

    // chunk planner
    logic [DELAY_W-1:0] s_rem;
    logic [QUOT_W-1:0]  s_q;
    logic               c_ms_sel;
    logic [9:0]         c_ms_raw, c_ms;
    logic [7:0]         c_tpm;
    logic [17:0]        c_tprod;
    logic [19:0]        c_used;
    logic [CW-1:0]      c_tick_ms;
    logic [DELAY_W-1:0] c_rem_ms;
    logic [QUOT_W-1:0]  c_q_ms;
    logic [CW-1:0]      c_tick_us_raw, c_tick_us;
    logic [DELAY_W-1:0] c_rem_us;
    logic [16:0]        c_x_us;
    logic [13:0]        c_y_us;
    logic [28:0]        c_p_us;
    logic [QUOT_W-1:0]  c_q_us;
    logic [CW-1:0]      c_ticks;
    logic [DELAY_W-1:0] c_rem;
    logic [QUOT_W-1:0]  c_q;

    // tick path
    logic [PRE_W-1:0]   w_div;
    logic               w_hit;
    logic [CW-1:0]      w_ctl_dec;

    logic [PRE_W-1:0]   n_pc;
    logic [CW-1:0]      n_ctl;
    logic               n_ms;
    logic [DELAY_W-1:0] n_rem;
    logic [QUOT_W-1:0]  n_q;
    logic               n_run;
    logic [OVF_W-1:0]   n_ovf;
    logic               n_exp;

    assign o_ready = !r_ovalid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_start = i_item.req_type;

    assign s_rem = w_start ? i_item.delay_us : r_rem;
    assign s_q   = w_start ? i_item.quot : r_q;

    assign c_ms_sel = s_rem >= {16'b0, i_cfg.ms_switch_us};

    // millisecond chunk
    assign c_ms_raw  = (s_q > {13'b0, i_cfg.max_chunk_ms}) ? i_cfg.max_chunk_ms : s_q[9:0];
    assign c_ms      = (c_ms_raw == '0) ? 10'd1 : c_ms_raw;
    assign c_tpm     = (i_cfg.ticks_per_ms == '0) ? 8'd1 : i_cfg.ticks_per_ms;
    assign c_tprod   = {8'b0, c_ms} * {10'b0, c_tpm};
    assign c_used    = {10'b0, c_ms} * US_PER_MS;
    assign c_tick_ms = (c_tprod > 18'(LIM)) ? LIM : c_tprod[CW-1:0];
    assign c_rem_ms  = (s_rem > {12'b0, c_used}) ? s_rem - {12'b0, c_used} : '0;
    assign c_q_ms    = (s_q > {13'b0, c_ms}) ? s_q - {13'b0, c_ms} : '0;

    // microsecond chunk; here s_rem is below the 16-bit switch threshold
    assign c_tick_us_raw = (s_rem > 32'(LIM)) ? LIM : s_rem[CW-1:0];
    assign c_tick_us     = (c_tick_us_raw == '0) ? CW'(1) : c_tick_us_raw;
    assign c_rem_us      = (s_rem > 32'(c_tick_us)) ? s_rem - 32'(c_tick_us) : '0;
    assign c_x_us        = {1'b0, c_rem_us[15:0]} + CEIL_ADD;
    assign c_y_us        = c_x_us[16:3];
    assign c_p_us        = {15'b0, c_y_us} * {14'b0, US_RECIP};
    assign c_q_us        = {16'b0, c_p_us[27:21]};

    assign c_ticks = c_ms_sel ? c_tick_ms : c_tick_us;
    assign c_rem   = c_ms_sel ? c_rem_ms : c_rem_us;
    assign c_q     = c_ms_sel ? c_q_ms : c_q_us;

    assign w_div     = r_ms ? i_cfg.ms_prescale : i_cfg.us_prescale;
    assign w_hit     = r_pc >= w_div;
    assign w_ctl_dec = (r_ctl != '0) ? r_ctl - CW'(1) : r_ctl;

    always_comb begin
        n_pc  = r_pc;
        n_ctl = r_ctl;
        n_ms  = r_ms;
        n_rem = r_rem;
        n_q   = r_q;
        n_run = r_run;
        n_ovf = r_ovf;
        n_exp = 1'b0;
        if (w_start) begin
            n_pc  = '0;
            n_ctl = c_ticks;
            n_ms  = c_ms_sel;
            n_rem = c_rem;
            n_q   = c_q;
            n_run = 1'b1;
        end else if (r_run) begin
            if (w_hit) begin
                n_pc  = '0;
                n_ctl = w_ctl_dec;
                if (w_ctl_dec == '0) begin
                    n_ovf = r_ovf + OVF_W'(1);
                    if (r_rem != '0) begin
                        n_ctl = c_ticks;
                        n_ms  = c_ms_sel;
                        n_rem = c_rem;
                        n_q   = c_q;
                    end else begin
                        n_run = 1'b0;
                        n_exp = 1'b1;
                    end
                end
            end else begin
                n_pc = r_pc + PRE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_ctl    <= CW'(CHUNK_TICKS_RST);
            r_ms     <= 1'b0;
            r_rem    <= '0;
            r_q      <= '0;
            r_run    <= 1'b0;
            r_ovf    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_pc     <= n_pc;
                r_ctl    <= n_ctl;
                r_ms     <= n_ms;
                r_rem    <= n_rem;
                r_q      <= n_q;
                r_run    <= n_run;
                r_ovf    <= n_ovf;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_oexp  <= n_exp;
            r_obusy <= n_run;
            r_oovf  <= n_ovf;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_expired   = r_oexp;
    assign o_busy      = r_obusy;
    assign o_overflows = r_oovf;

    `COSUT_ASSERT(a_ctl_nonzero, r_run |-> (r_ctl != '0), "running with empty chunk")
    `COSUT_ASSERT(a_rem_q_match, (r_rem == '0) == (r_q == '0), "remaining and ms quotient disagree")
    `COSUT_ASSERT(a_stop_pc_clear, !r_run |-> (r_pc == '0), "prescaler left dirty while stopped")
    `COSUT_ASSERT(a_exp_counts, (w_acc && n_exp) |=> (r_ovf == $past(r_ovf) + OVF_W'(1)), "expiry without overflow")
    `COSUT_ASSERT_RST(a_rst_no_out, !i_rst_n |=> !r_ovalid, "result valid after reset")

endmodule
